// ===== rtl/core/tod_pkg.sv =====
package tod_pkg;

    localparam int TICKS_PER_MILLI = 1000;
    localparam int MICRO_W = (TICKS_PER_MILLI > 1) ? $clog2(TICKS_PER_MILLI) : 1;

    localparam int MILLIS_PER_SEC = 1000;
    localparam int SECS_PER_HOUR  = 3600;
    localparam int SECS_PER_MIN   = 60;
    localparam int SECS_PER_DAY   = 86400;
    localparam int MILLIS_PER_DAY = 86400000;

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_MANUAL = 2'd1;
    localparam logic [1:0] REQ_GPS    = 2'd2;

    localparam logic [1:0] SRC_NONE = 2'd0;

    typedef struct packed {
        logic [1:0]  req;
        logic        set_ok;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [16:0] secs;
    } item_t;

endpackage

// ===== rtl/core/tod_in_stage.sv =====
module tod_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [1:0]          req_type,
    input  logic [7:0]          set_hour,
    input  logic [7:0]          set_minute,
    input  logic [7:0]          set_second,
    input  logic                ready,
    output logic                s1_valid,
    output tod_pkg::item_t      s1_item
);

    logic           valid_reg;
    tod_pkg::item_t item_reg;
    tod_pkg::item_t item_next;

    assign item_stall = valid_reg && !ready;
    assign s1_valid   = valid_reg;
    assign s1_item    = item_reg;

    always_comb
    begin
        item_next.req    = req_type;
        item_next.set_ok = (set_hour < 8'd24) && (set_minute < 8'd60) && (set_second < 8'd60);
        item_next.hour   = set_hour[4:0];
        item_next.minute = set_minute[5:0];
        item_next.second = set_second[5:0];
        item_next.secs   = 17'(17'(set_hour[4:0]) * 17'(tod_pkg::SECS_PER_HOUR))
                         + 17'(17'(set_minute[5:0]) * 17'(tod_pkg::SECS_PER_MIN))
                         + 17'(set_second[5:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/core/tod_core.sv =====
module tod_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s1_valid,
    input  tod_pkg::item_t      s1_item,
    output logic                ready,
    output logic                result_valid,
    input  logic                result_stall,
    output logic                status,
    output logic                clock_valid,
    output logic [1:0]          clock_source,
    output logic [4:0]          hour_now,
    output logic [5:0]          minute_now,
    output logic [5:0]          second_now,
    output logic [16:0]         seconds_of_day,
    output logic [26:0]         millis_of_day,
    output logic [31:0]         age_millis
);

    localparam int MW = tod_pkg::MICRO_W;

    logic                valid_flag_reg,  valid_flag_next;
    logic [1:0]          source_reg,      source_next;
    logic [MW-1:0]       micros_reg,      micros_next;
    logic [9:0]          millis_reg,      millis_next;
    logic [4:0]          hour_reg,        hour_next;
    logic [5:0]          minute_reg,      minute_next;
    logic [5:0]          second_reg,      second_next;
    logic [16:0]         day_secs_reg,    day_secs_next;
    logic [26:0]         day_millis_reg,  day_millis_next;
    logic [31:0]         age_reg,         age_next;

    logic                out_valid_reg;
    logic                status_reg,      status_next;
    logic                advance;
    logic                tick;
    logic                is_set;
    logic                load;
    logic                milli_done;
    logic                sec_done;
    logic                min_done;
    logic                hour_done;

    assign ready   = !out_valid_reg || !result_stall;
    assign advance = s1_valid && ready;

    assign tick   = (s1_item.req == tod_pkg::REQ_TICK) && valid_flag_reg;
    assign is_set = (s1_item.req == tod_pkg::REQ_MANUAL) || (s1_item.req == tod_pkg::REQ_GPS);
    assign load   = is_set && s1_item.set_ok;

    assign milli_done = tick && (micros_reg == MW'(tod_pkg::TICKS_PER_MILLI - 1));
    assign sec_done   = milli_done && (millis_reg == 10'(tod_pkg::MILLIS_PER_SEC - 1));
    assign min_done   = sec_done && (second_reg == 6'(tod_pkg::SECS_PER_MIN - 1));
    assign hour_done  = min_done && (minute_reg == 6'(tod_pkg::SECS_PER_MIN - 1));

    always_comb
    begin
        valid_flag_next = valid_flag_reg;
        source_next     = source_reg;
        micros_next     = micros_reg;
        millis_next     = millis_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        second_next     = second_reg;
        day_secs_next   = day_secs_reg;
        day_millis_next = day_millis_reg;
        age_next        = age_reg;
        status_next     = is_set && !s1_item.set_ok;

        if (load)
        begin
            valid_flag_next = 1'b1;
            source_next     = s1_item.req;
            micros_next     = '0;
            millis_next     = '0;
            hour_next       = s1_item.hour;
            minute_next     = s1_item.minute;
            second_next     = s1_item.second;
            day_secs_next   = s1_item.secs;
            day_millis_next = 27'(27'(s1_item.secs) * 27'(tod_pkg::MILLIS_PER_SEC));
            age_next        = '0;
        end
        else if (tick)
        begin
            micros_next = milli_done ? '0 : micros_reg + MW'(1);
            if (milli_done)
            begin
                age_next        = age_reg + 32'd1;
                day_millis_next = (day_millis_reg == 27'(tod_pkg::MILLIS_PER_DAY - 1))
                                ? '0 : day_millis_reg + 27'd1;
                millis_next     = sec_done ? '0 : millis_reg + 10'd1;
            end
            if (sec_done)
            begin
                second_next   = min_done ? '0 : second_reg + 6'd1;
                day_secs_next = (day_secs_reg == 17'(tod_pkg::SECS_PER_DAY - 1))
                              ? '0 : day_secs_reg + 17'd1;
            end
            if (min_done)
            begin
                minute_next = hour_done ? '0 : minute_reg + 6'd1;
            end
            if (hour_done)
            begin
                hour_next = (hour_reg == 5'd23) ? '0 : hour_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_flag_reg <= 1'b0;
            source_reg     <= tod_pkg::SRC_NONE;
            micros_reg     <= '0;
            millis_reg     <= '0;
            hour_reg       <= '0;
            minute_reg     <= '0;
            second_reg     <= '0;
            day_secs_reg   <= '0;
            day_millis_reg <= '0;
            age_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ready)
            begin
                out_valid_reg <= s1_valid;
            end
            if (advance)
            begin
                valid_flag_reg <= valid_flag_next;
                source_reg     <= source_next;
                micros_reg     <= micros_next;
                millis_reg     <= millis_next;
                hour_reg       <= hour_next;
                minute_reg     <= minute_next;
                second_reg     <= second_next;
                day_secs_reg   <= day_secs_next;
                day_millis_reg <= day_millis_next;
                age_reg        <= age_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign status         = status_reg;
    assign clock_valid    = valid_flag_reg;
    assign clock_source   = source_reg;
    assign hour_now       = hour_reg;
    assign minute_now     = minute_reg;
    assign second_now     = second_reg;
    assign seconds_of_day = day_secs_reg;
    assign millis_of_day  = day_millis_reg;
    assign age_millis     = age_reg;

endmodule

// ===== rtl/core/time_of_day_clock.sv =====
// Time-of-day clock driven by one-microsecond tick transfers and set transfers
// (manual or GPS). Every accepted transfer yields exactly one result transfer with
// the clock state after it; a set out of range returns status 1 and leaves the
// state alone. One item is accepted per cycle, back to back, unless the result
// side stalls. An input register holds the request and the set time folded into
// seconds, and then the state registers, which also form the result register,
// take the updated counters. A stall on the result side holds the pipeline; up to
// two items are in flight. Ticks are ignored until the first good set.
module time_of_day_clock
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  set_hour,
    input  logic [7:0]  set_minute,
    input  logic [7:0]  set_second,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        status,
    output logic        clock_valid,
    output logic [1:0]  clock_source,
    output logic [4:0]  hour_now,
    output logic [5:0]  minute_now,
    output logic [5:0]  second_now,
    output logic [16:0] seconds_of_day,
    output logic [26:0] millis_of_day,
    output logic [31:0] age_millis
);

    logic           ready;
    logic           s1_valid;
    tod_pkg::item_t s1_item;

    tod_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .req_type   (req_type),
        .set_hour   (set_hour),
        .set_minute (set_minute),
        .set_second (set_second),
        .ready      (ready),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item)
    );

    tod_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s1_valid       (s1_valid),
        .s1_item        (s1_item),
        .ready          (ready),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .status         (status),
        .clock_valid    (clock_valid),
        .clock_source   (clock_source),
        .hour_now       (hour_now),
        .minute_now     (minute_now),
        .second_now     (second_now),
        .seconds_of_day (seconds_of_day),
        .millis_of_day  (millis_of_day),
        .age_millis     (age_millis)
    );

endmodule
